[hw/rtl/c3rgb_pkg.sv]
`timescale 1ns / 1ps

package c3rgb_pkg;

    // Configuration register indexes and widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 2'd3;

    localparam int KTOP_W = 48;
    localparam int KBOT_W = 24;
    localparam int DIM_W  = 11;

    localparam logic [KTOP_W-1:0] KTOP_RESET = 48'h0001_0000_0000;
    localparam logic [KBOT_W-1:0] KBOT_RESET = 24'h00_0000;
    localparam logic [DIM_W-1:0]  DIM_RESET  = 11'd1024;

    // Pixel layout: red in the low byte, then green, then blue.
    localparam int CH_W      = 8;
    localparam int PIXEL_W   = 3 * CH_W;
    localparam int PIXEL_MAX = 255;

    // Input beat kinds.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Result queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int USED_W     = 4;

    typedef logic [PIXEL_W-1:0] t_pixel;

    // Travels with an item from the window stage into the multiply-accumulate.
    typedef struct packed {
        logic emit;
        logic top_off;
        logic bot_off;
        logic left_off;
        logic right_off;
        logic last;
    } t_emit_ctl;

    typedef struct packed {
        logic            frame_done;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_result;

endpackage

[hw/rtl/c3rgb_ifs.sv]
`timescale 1ns / 1ps

// Pixel channel into the filter.
interface c3rgb_in_if;
    import c3rgb_pkg::*;

    logic            valid;
    logic            ready;
    logic            action;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, action, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

// Filtered pixel channel out of the filter.
interface c3rgb_out_if;
    import c3rgb_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_done;

    modport source (output valid, out_red, out_green, out_blue, frame_done, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_done, output ready);
endinterface

[hw/rtl/c3rgb_mac.sv]
`timescale 1ns / 1ps

module c3rgb_mac #(
    parameter int COEF_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  c3rgb_pkg::t_emit_ctl              i_ctl,
    input  c3rgb_pkg::t_pixel                 i_win [9],
    input  logic [c3rgb_pkg::KTOP_W-1:0]      i_kern_top,
    input  logic [c3rgb_pkg::KBOT_W-1:0]      i_kern_bot,
    output logic                              o_valid,
    output c3rgb_pkg::t_result                o_res
);
    import c3rgb_pkg::*;

    localparam int PW  = COEF_BITS + CH_W + 1;
    localparam int RSW = PW + 2;
    localparam int SW  = PW + 4;

    logic [KTOP_W+6*COEF_BITS-1:0] w_top_pad;
    logic [KBOT_W+3*COEF_BITS-1:0] w_bot_pad;
    logic signed [COEF_BITS-1:0]   w_coef [9];
    t_pixel                        w_tap [9];
    logic signed [PW-1:0]          r_prod [9][3];
    logic signed [RSW-1:0]         r_row_sum [3][3];
    logic signed [SW-1:0]          w_total [3];
    logic [CH_W-1:0]               w_chan [3];
    logic                          r_a_valid;
    logic                          r_a_last;
    logic                          r_b_valid;
    logic                          r_b_last;

    // Coefficients past the end of a register read as zero.
    assign w_top_pad = {{(6*COEF_BITS){1'b0}}, i_kern_top};
    assign w_bot_pad = {{(3*COEF_BITS){1'b0}}, i_kern_bot};

    // Pick each coefficient; a tap outside the image contributes nothing, so both its
    // coefficient and its pixel are forced to zero.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (r < 2) begin
                    w_coef[r*3+c] = w_top_pad[(r*3+c)*COEF_BITS +: COEF_BITS];
                end else begin
                    w_coef[r*3+c] = w_bot_pad[c*COEF_BITS +: COEF_BITS];
                end
                w_tap[r*3+c] = i_win[r*3+c];
                if ((r == 0 && i_ctl.top_off) || (r == 2 && i_ctl.bot_off) ||
                    (c == 0 && i_ctl.left_off) || (c == 2 && i_ctl.right_off)) begin
                    w_coef[r*3+c] = '0;
                    w_tap[r*3+c]  = '0;
                end
            end
        end
    end

    // First stage: one small product per tap and channel.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 9; i++) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_prod[i][ch] <= $signed({1'b0, w_tap[i][CH_W*ch +: CH_W]}) * w_coef[i];
            end
        end
        r_a_last <= i_ctl.last;
    end

    // Second stage: sum each window row.
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_row_sum[r][ch] <= RSW'(r_prod[r*3][ch]) + RSW'(r_prod[r*3+1][ch])
                                    + RSW'(r_prod[r*3+2][ch]);
            end
        end
        r_b_last <= r_a_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_ctl.emit;
            r_b_valid <= r_a_valid;
        end
    end

    // Final add of the three rows and clamp into the pixel range.
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_total[ch] = SW'(r_row_sum[0][ch]) + SW'(r_row_sum[1][ch])
                          + SW'(r_row_sum[2][ch]);
            if (w_total[ch] < 0) begin
                w_chan[ch] = '0;
            end else if (w_total[ch] > $signed(SW'(PIXEL_MAX))) begin
                w_chan[ch] = CH_W'(PIXEL_MAX);
            end else begin
                w_chan[ch] = w_total[ch][CH_W-1:0];
            end
        end
    end

    assign o_valid          = r_b_valid;
    assign o_res.frame_done = r_b_last;
    assign o_res.red        = w_chan[0];
    assign o_res.green      = w_chan[1];
    assign o_res.blue       = w_chan[2];

endmodule

[hw/rtl/conv3x3_rgb_clamp.sv]
`timescale 1ns / 1ps

// Streaming 3x3 RGB convolution with clamping to 0..255. The block takes one
// beat per clock while a queue credit is free, and every result passes the
// window stage and both multiply-accumulate stages into the output queue before
// it is offered. Pixels arrive in raster order; the result for a pixel comes
// out when the input is one row and one pixel further on, so after the last
// pixel of a frame the source sends flush beats (action 1) until the result
// carrying frame_done has come out; a flush beat outside that phase, and a
// pixel beat inside it, is taken and dropped. Both line stores share one
// memory with a single read port and a single write port; an item reads its
// column in the cycle it is taken, a pixel writes it back in the next cycle,
// with a bypass when the next item wants the same column. An eight-entry result
// queue, with credits counted at the input, lets the block keep taking beats
// while the sink stalls. Writing image_width or image_height restarts the
// frame; configuration is to be written only while no item is in flight.
module conv3x3_rgb_clamp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COEF_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [c3rgb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [c3rgb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    c3rgb_in_if.sink                            i_pix,
    c3rgb_out_if.source                         o_res
);
    import c3rgb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Configuration registers.
    logic [KTOP_W-1:0] r_kern_top;
    logic [KBOT_W-1:0] r_kern_bot;
    logic [DIM_W-1:0]  r_img_w;
    logic [DIM_W-1:0]  r_img_h;
    logic              w_restart;

    // Frame position and drain state.
    logic [CW-1:0] r_in_col,  n_in_col;
    logic [RW-1:0] r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;
    logic          r_drain,   n_drain;
    logic [CW-1:0] w_last_col;
    logic [RW-1:0] w_last_row;

    // Accept-stage decode.
    logic          w_acc;
    logic          w_do_pix;
    logic          w_do_flush;
    logic          w_take;
    logic          w_pix_emit;
    logic          w_emit;
    logic          w_out_last;
    logic [CW-1:0] w_addr;
    t_emit_ctl     w_ctl;

    // Line store memory: upper row in the high half, lower row in the low half.
    logic [2*PIXEL_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIXEL_W-1:0] r_mem_q;
    logic [2*PIXEL_W-1:0] r_fwd_data;
    logic [2*PIXEL_W-1:0] w_entry;

    // Window stage.
    logic          r_s1_valid;
    logic          r_s1_pix;
    logic          r_s1_fwd;
    logic [CW-1:0] r_s1_addr;
    t_pixel        r_s1_px;
    t_emit_ctl     r_s1_ctl;
    t_emit_ctl     r_s2_ctl;
    t_pixel        w_up;
    t_pixel        w_lo;
    t_pixel        w_bot;
    t_pixel        r_win [9];

    // Multiply-accumulate result and output queue.
    logic                 w_mac_valid;
    t_result              w_mac_res;
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW:0]     r_wr_ptr;
    logic [FIFO_AW:0]     r_rd_ptr;
    logic [USED_W-1:0]    r_used;
    logic                 w_pop;
    t_result              w_head;

    // Effective frame size: zero acts as one, oversize acts as the maximum.
    always_comb begin
        if (r_img_w == '0) begin
            w_last_col = '0;
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            w_last_col = CW'(MAX_WIDTH - 1);
        end else begin
            w_last_col = CW'(r_img_w - DIM_W'(1));
        end
        if (r_img_h == '0) begin
            w_last_row = '0;
        end else if (32'(r_img_h) > 32'(MAX_HEIGHT)) begin
            w_last_row = RW'(MAX_HEIGHT - 1);
        end else begin
            w_last_row = RW'(r_img_h - DIM_W'(1));
        end
    end

    // Configuration writes.
    assign w_restart = i_cfg_we && (i_cfg_idx == CFG_WIDTH || i_cfg_idx == CFG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kern_top <= KTOP_RESET;
            r_kern_bot <= KBOT_RESET;
            r_img_w    <= DIM_RESET;
            r_img_h    <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KERNEL_TOP: r_kern_top <= i_cfg_data[KTOP_W-1:0];
                CFG_KERNEL_BOT: r_kern_bot <= i_cfg_data[KBOT_W-1:0];
                CFG_WIDTH:      r_img_w    <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:     r_img_h    <= i_cfg_data[DIM_W-1:0];
                default:        r_img_h    <= r_img_h;
            endcase
        end
    end

    // Decode the accepted beat.
    assign i_pix.ready = (r_used < USED_W'(FIFO_DEPTH));
    assign w_acc       = i_pix.valid && i_pix.ready;
    assign w_do_pix    = w_acc && (i_pix.action == ACT_PIXEL) && !r_drain;
    assign w_do_flush  = w_acc && (i_pix.action == ACT_FLUSH) && r_drain;
    assign w_take      = w_do_pix || w_do_flush;
    assign w_pix_emit  = (r_in_row != '0 && r_in_col != '0) || (32'(r_in_row) >= 32'd2);
    assign w_emit      = w_do_flush || (w_do_pix && w_pix_emit);
    assign w_out_last  = (r_out_col == w_last_col) && (r_out_row == w_last_row);

    // A flush reads the column to the right of the next output, wrapping round.
    always_comb begin
        if (w_do_flush) begin
            w_addr = (r_out_col == w_last_col) ? '0 : r_out_col + CW'(1);
        end else begin
            w_addr = r_in_col;
        end
    end

    always_comb begin
        w_ctl.emit      = w_emit;
        w_ctl.top_off   = (r_out_row == '0);
        w_ctl.bot_off   = (r_out_row == w_last_row);
        w_ctl.left_off  = (r_out_col == '0);
        w_ctl.right_off = (r_out_col == w_last_col);
        w_ctl.last      = w_out_last;
    end

    // Next frame position.
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_drain   = r_drain;
        if (w_do_pix) begin
            if (r_in_col == w_last_col) begin
                n_in_col = '0;
                if (r_in_row == w_last_row) begin
                    n_in_row = '0;
                    n_drain  = 1'b1;
                end else begin
                    n_in_row = r_in_row + RW'(1);
                end
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
        if (w_emit) begin
            if (w_out_last) begin
                n_out_col = '0;
                n_out_row = '0;
                n_drain   = 1'b0;
            end else if (r_out_col == w_last_col) begin
                n_out_col = '0;
                n_out_row = r_out_row + RW'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_drain   <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_drain   <= n_drain;
        end
    end

    // Line store: read when a beat is taken, write back from the window stage.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_mem_q <= r_mem[w_addr];
        end
        if (r_s1_valid && r_s1_pix) begin
            r_mem[r_s1_addr] <= {w_lo, r_s1_px};
        end
    end

    // Window stage registers; the bypass covers a write to the column being read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
            r_s1_ctl   <= '0;
            r_s2_ctl   <= '0;
        end else begin
            r_s1_valid <= w_take;
            r_s1_fwd   <= w_take && r_s1_valid && r_s1_pix && (r_s1_addr == w_addr);
            r_s1_ctl   <= w_ctl;
            r_s2_ctl   <= r_s1_valid ? r_s1_ctl : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pix   <= w_do_pix;
        r_s1_addr  <= w_addr;
        r_s1_px    <= {i_pix.in_blue, i_pix.in_green, i_pix.in_red};
        r_fwd_data <= {w_lo, r_s1_px};
    end

    assign w_entry = r_s1_fwd ? r_fwd_data : r_mem_q;
    assign w_up    = w_entry[2*PIXEL_W-1:PIXEL_W];
    assign w_lo    = w_entry[PIXEL_W-1:0];
    assign w_bot   = r_s1_pix ? r_s1_px : '0;

    // Shift the 3x3 window one column left and load the new right column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= w_up;
            r_win[5] <= w_lo;
            r_win[8] <= w_bot;
        end
    end

    c3rgb_mac #(
        .COEF_BITS (COEF_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_s2_ctl),
        .i_win      (r_win),
        .i_kern_top (r_kern_top),
        .i_kern_bot (r_kern_bot),
        .o_valid    (w_mac_valid),
        .o_res      (w_mac_res)
    );

    // Result queue; credits cover every result still in the pipeline.
    assign w_pop  = o_res.valid && o_res.ready;
    assign w_head = r_fifo[r_rd_ptr[FIFO_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (w_mac_valid) begin
            r_fifo[r_wr_ptr[FIFO_AW-1:0]] <= w_mac_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            if (w_mac_valid) begin
                r_wr_ptr <= r_wr_ptr + (FIFO_AW+1)'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + (FIFO_AW+1)'(1);
            end
            if (w_emit && !w_pop) begin
                r_used <= r_used + USED_W'(1);
            end else if (!w_emit && w_pop) begin
                r_used <= r_used - USED_W'(1);
            end
        end
    end

    assign o_res.valid      = (r_wr_ptr != r_rd_ptr);
    assign o_res.out_red    = w_head.red;
    assign o_res.out_green  = w_head.green;
    assign o_res.out_blue   = w_head.blue;
    assign o_res.frame_done = w_head.frame_done;

    // Credits never exceed the queue, and cover what already sits in it.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(FIFO_DEPTH))
        else $error("result credit count above queue depth");

    a_fifo_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        USED_W'(r_wr_ptr - r_rd_ptr) <= r_used)
        else $error("result queue holds more than its credits");

    // The bypass is only taken behind a pixel write in the window stage.
    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> $past(r_s1_valid && r_s1_pix))
        else $error("line store bypass without a preceding write");

    // Column counters stay inside the effective width.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_col <= w_last_col && r_out_col <= w_last_col)
        else $error("column counter beyond image width");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import c3rgb_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BEATS  = 600;
    localparam int LONG_HOLD     = 100;
    localparam longint LIMIT_NS  = 64'd10_000_000;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    c3rgb_in_if  pix_if ();
    c3rgb_out_if res_if ();

    conv3x3_rgb_clamp #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H),
        .COEF_BITS  (8)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if.sink),
        .o_res      (res_if.source)
    );

    always #10 clk = ~clk;

    // Mirror of the filter's registers and internal state.
    logic [KTOP_W-1:0] k_top;
    logic [KBOT_W-1:0] k_bot;
    logic [DIM_W-1:0]  img_w;
    logic [DIM_W-1:0]  img_h;
    t_pixel            upper_line [MAX_W];
    t_pixel            lower_line [MAX_W];
    t_pixel            win [9];
    int unsigned       col_in;
    int unsigned       row_in;
    int unsigned       out_pos;
    bit                draining;

    t_result     filtered_q [$];
    int unsigned error_count = 0;
    int unsigned beats_used  = 0;
    int unsigned sink_wait   = 0;
    bit          sink_hold   = 1'b0;
    bit          burst_mode  = 1'b0;

    // Effective frame dimension: zero acts as one, anything above the maximum as the maximum.
    function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic int kernel_coef(int idx);
        if (idx < 6) return int'($signed(k_top[8*idx +: 8]));
        return int'($signed(k_bot[8*(idx-6) +: 8]));
    endfunction

    function automatic logic [CH_W-1:0] clamp_channel(longint s);
        if (s < 0) return '0;
        if (s > PIXEL_MAX) return CH_W'(PIXEL_MAX);
        return CH_W'(s);
    endfunction

    function automatic void restart_frame();
        col_in   = 0;
        row_in   = 0;
        out_pos  = 0;
        draining = 1'b0;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_KERNEL_TOP: begin
                k_top = data[KTOP_W-1:0];
            end
            CFG_KERNEL_BOT: begin
                k_bot = data[KBOT_W-1:0];
            end
            CFG_WIDTH: begin
                img_w = data[DIM_W-1:0];
                restart_frame();
            end
            CFG_HEIGHT: begin
                img_h = data[DIM_W-1:0];
                restart_frame();
            end
            default: begin
            end
        endcase
    endfunction

    // The window moves one column left; the new column enters on the right.
    function automatic void shift_window(t_pixel top, t_pixel mid, t_pixel bot);
        for (int r = 0; r < 3; r++) begin
            win[r*3]     = win[r*3 + 1];
            win[r*3 + 1] = win[r*3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = bot;
    endfunction

    // Convolve the window for output position out_pos, masking taps outside the frame.
    function automatic void push_filtered(int unsigned w, int unsigned h);
        int unsigned orow;
        int unsigned ocol;
        longint      acc [3];
        int          k;
        t_result     res;
        orow = out_pos / w;
        ocol = out_pos % w;
        for (int ch = 0; ch < 3; ch++) acc[ch] = 0;
        for (int r = 0; r < 3; r++) begin
            if (r == 0 && orow == 0) continue;
            if (r == 2 && orow + 1 >= h) continue;
            for (int c = 0; c < 3; c++) begin
                if (c == 0 && ocol == 0) continue;
                if (c == 2 && ocol + 1 >= w) continue;
                k = kernel_coef(r*3 + c);
                for (int ch = 0; ch < 3; ch++)
                    acc[ch] += longint'(win[r*3 + c][8*ch +: 8]) * longint'(k);
            end
        end
        res.red   = clamp_channel(acc[0]);
        res.green = clamp_channel(acc[1]);
        res.blue  = clamp_channel(acc[2]);
        if (out_pos + 1 >= w * h) begin
            res.frame_done = 1'b1;
            out_pos        = 0;
            draining       = 1'b0;
        end else begin
            res.frame_done = 1'b0;
            out_pos++;
        end
        filtered_q.push_back(res);
    endfunction

    // Advance the mirror by one accepted beat; returns 0 when the beat is dropped.
    function automatic bit filter_beat(logic act, t_pixel px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        bit          emits;
        t_pixel      up;
        t_pixel      lo;
        w = eff_dim(img_w, MAX_W);
        h = eff_dim(img_h, MAX_H);
        if (act == ACT_FLUSH) begin
            if (!draining) return 1'b0;
            c = out_pos % w + 1;
            if (c >= w) c = 0;
            shift_window(upper_line[c], lower_line[c], '0);
            push_filtered(w, h);
            return 1'b1;
        end
        if (draining) return 1'b0;
        c = col_in;
        r = row_in;
        if (c >= w) c = 0;
        up = upper_line[c];
        lo = lower_line[c];
        shift_window(up, lo, px);
        upper_line[c] = lo;
        lower_line[c] = px;
        emits = (r >= 1 && c >= 1) || r >= 2;
        if (c + 1 >= w) begin
            col_in = 0;
            if (r + 1 >= h) begin
                row_in   = 0;
                draining = 1'b1;
            end else begin
                row_in = r + 1;
            end
        end else begin
            col_in = c + 1;
        end
        if (emits) push_filtered(w, h);
        return 1'b1;
    endfunction

    function automatic int unsigned idle_draw();
        if (burst_mode) return 0;
        return $urandom_range(0, 5);
    endfunction

    // Channel values lean towards the extremes so that clamping and carries get exercised.
    function automatic logic [CH_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        return {pick_channel(), pick_channel(), pick_channel()};
    endfunction

    // Either fully random coefficients or small ones from -2 to 3.
    function automatic logic [KTOP_W-1:0] kernel_bytes(int n, bit mild);
        logic [KTOP_W-1:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v[8*i +: 8] = mild ? 8'(int'($urandom_range(0, 5)) - 2) : 8'($urandom);
        return v;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Sink side: the ready line follows the drawn stall and any long hold-off.
    always @(negedge clk) begin
        if (sink_hold || sink_wait > 0) begin
            res_if.ready <= 1'b0;
            if (sink_wait > 0) sink_wait--;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Each result beat is compared with the oldest filtered pixel still waiting.
    always @(posedge clk) begin : result_check
        t_result want;
        if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            sink_wait = idle_draw();
            if (filtered_q.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, actual r=%0d g=%0d b=%0d done=%0b",
                         $time, res_if.out_red, res_if.out_green, res_if.out_blue,
                         res_if.frame_done);
                error_count++;
            end else begin
                want = filtered_q.pop_front();
                check_field("out_red", want.red, res_if.out_red);
                check_field("out_green", want.green, res_if.out_green);
                check_field("out_blue", want.blue, res_if.out_blue);
                check_field("frame_done", want.frame_done, res_if.frame_done);
            end
        end
    end

    // Offer one beat after a random gap and hold it until the filter takes it.
    task automatic send_beat(logic act, t_pixel px);
        int unsigned gap;
        gap = idle_draw();
        @(negedge clk);
        repeat (gap) begin
            pix_if.valid <= 1'b0;
            @(negedge clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.action   <= act;
        pix_if.in_red   <= px[7:0];
        pix_if.in_green <= px[15:8];
        pix_if.in_blue  <= px[23:16];
        do @(posedge clk); while (pix_if.ready !== 1'b1);
        if (filter_beat(act, px)) beats_used++;
    endtask

    // Stop offering beats, let every expected result out, then give the pipeline time to empty.
    task automatic wait_quiet();
        @(negedge clk);
        pix_if.valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic set_kernel(logic [KTOP_W-1:0] top, logic [KBOT_W-1:0] bot);
        wait_quiet();
        write_reg(CFG_KERNEL_TOP, top);
        write_reg(CFG_KERNEL_BOT, bot);
    endtask

    task automatic set_frame(logic [DIM_W-1:0] w_val, logic [DIM_W-1:0] h_val);
        wait_quiet();
        write_reg(CFG_WIDTH, w_val);
        write_reg(CFG_HEIGHT, h_val);
    endtask

    // Flush beats until the frame's last result has been produced; noise adds dropped pixels.
    task automatic drain_frame(bit noise);
        while (draining) begin
            if (noise && $urandom_range(0, 9) == 0) send_beat(ACT_PIXEL, random_pixel());
            send_beat(ACT_FLUSH, random_pixel());
        end
    endtask

    // One frame of random pixels. A non-zero stop_after abandons the frame part way,
    // and a non-zero pause_at makes the source wait for all results at that pixel.
    task automatic run_frame(logic [DIM_W-1:0] w_val, logic [DIM_W-1:0] h_val,
                             int unsigned stop_after, int unsigned pause_at, bit noise);
        int unsigned total;
        set_frame(w_val, h_val);
        total = eff_dim(img_w, MAX_W) * eff_dim(img_h, MAX_H);
        if (stop_after != 0 && stop_after < total) total = stop_after;
        for (int unsigned i = 0; i < total; i++) begin
            if (pause_at != 0 && i == pause_at) wait_quiet();
            if (noise && $urandom_range(0, 19) == 0) send_beat(ACT_FLUSH, random_pixel());
            send_beat(ACT_PIXEL, random_pixel());
        end
        drain_frame(noise);
    endtask

    task automatic hold_sink(int unsigned cycles);
        sink_hold = 1'b1;
        repeat (cycles) @(posedge clk);
        sink_hold = 1'b0;
    endtask

    // The reset kernel is the identity, so each pixel should come back unchanged.
    task automatic test_identity_kernel();
        logic [CH_W-1:0] edge_vals [9];
        edge_vals = '{8'h00, 8'hff, 8'h01, 8'hfe, 8'h80, 8'h7f, 8'h55, 8'haa, 8'h00};
        set_frame(3, 3);
        for (int i = 0; i < 9; i++)
            send_beat(ACT_PIXEL, {edge_vals[(i+2) % 9], edge_vals[(i+1) % 9], edge_vals[i]});
        drain_frame(1'b0);
    endtask

    // A flush outside the drain phase and a pixel inside it are both dropped.
    task automatic test_stray_beats();
        set_frame(2, 1);
        send_beat(ACT_FLUSH, random_pixel());
        send_beat(ACT_PIXEL, random_pixel());
        send_beat(ACT_PIXEL, random_pixel());
        send_beat(ACT_PIXEL, random_pixel());
        drain_frame(1'b0);
    endtask

    // Largest positive and negative coefficients drive the sums past both clamp limits.
    task automatic test_clamping();
        set_kernel(48'h7f7f_7f7f_7f7f, 24'h7f7f7f);
        run_frame(2, 2, 0, 0, 1'b0);
        set_kernel(48'h8080_8080_8080, 24'h808080);
        run_frame(2, 2, 0, 0, 1'b0);
    endtask

    // Zero dimensions act as one; the smallest real frame as well.
    task automatic test_dimension_limits();
        set_kernel(kernel_bytes(6, 1'b1), kernel_bytes(3, 1'b1));
        run_frame(0, 0, 0, 0, 1'b0);
        run_frame(1, 1, 0, 0, 1'b0);
        run_frame(1, 3, 0, 0, 1'b0);
    endtask

    // A frame cut short is discarded once the dimensions are written again.
    task automatic test_frame_restart();
        run_frame(3, 3, 5, 0, 1'b0);
        run_frame(3, 3, 0, 0, 1'b0);
    endtask

    // The sink holds off while the source streams without gaps, so the result queue fills.
    task automatic test_backpressure();
        set_kernel(kernel_bytes(6, 1'b1), kernel_bytes(3, 1'b1));
        burst_mode = 1'b1;
        fork
            hold_sink(LONG_HOLD);
            run_frame(8, 6, 0, 0, 1'b0);
        join
        burst_mode = 1'b0;
    endtask

    task automatic test_source_pause();
        run_frame(5, 4, 0, 8, 1'b0);
    endtask

    // Dimensions beyond the maximum act as the maximum; the frames are cut short.
    task automatic test_largest_sizes();
        set_kernel(kernel_bytes(6, 1'b1), kernel_bytes(3, 1'b1));
        run_frame(2047, 2047, 30, 0, 1'b0);
        run_frame(0, 2047, 30, 0, 1'b0);
    endtask

    // Mostly complete small frames with random kernels, some cut short, some with noise.
    task automatic test_random_frames();
        int unsigned      goal;
        int unsigned      stop_after;
        int unsigned      pause_at;
        logic [DIM_W-1:0] w_val;
        logic [DIM_W-1:0] h_val;
        goal = beats_used + RANDOM_BEATS;
        while (beats_used < goal) begin
            burst_mode = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 1) == 0)
                set_kernel(kernel_bytes(6, $urandom_range(0, 2) != 0),
                           kernel_bytes(3, $urandom_range(0, 2) != 0));
            case ($urandom_range(0, 9))
                0: w_val = DIM_W'($urandom_range(9, 40));
                1: w_val = '0;
                default: w_val = DIM_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0: h_val = DIM_W'($urandom_range(6, 12));
                1: h_val = '0;
                default: h_val = DIM_W'($urandom_range(1, 5));
            endcase
            stop_after = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 0;
            pause_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 0;
            run_frame(w_val, h_val, stop_after, pause_at, 1'b1);
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_KERNEL_TOP;
        cfg_data        = '0;
        pix_if.valid    = 1'b0;
        pix_if.action   = ACT_PIXEL;
        pix_if.in_red   = '0;
        pix_if.in_green = '0;
        pix_if.in_blue  = '0;
        res_if.ready    = 1'b0;

        // Mirror starts from the reset state.
        k_top = KTOP_RESET;
        k_bot = KBOT_RESET;
        img_w = DIM_RESET;
        img_h = DIM_RESET;
        for (int i = 0; i < MAX_W; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        restart_frame();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_identity_kernel();
        test_stray_beats();
        test_clamping();
        test_dimension_limits();
        test_frame_restart();
        test_backpressure();
        test_source_pause();
        test_largest_sizes();
        test_random_frames();

        wait_quiet();
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/c3rgb_pkg.sv
hw/rtl/c3rgb_ifs.sv
hw/rtl/c3rgb_mac.sv
hw/rtl/conv3x3_rgb_clamp.sv
verif/tb_top.sv
